/* hdl/assert_macros.svh */
// assertion macros shared by the pixel converter rtl
// no dependencies; define NO_ASSERTIONS to compile them out
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
`define ASSERT_PROP(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) (prop)) \
      else $error("assertion failed: property violated");
`define ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed: next-cycle check violated");
`else
`define ASSERT_PROP(lbl, clk, rst, prop)
`define ASSERT_NEXT(lbl, clk, rst, ante, cons)
`endif
`endif

/* hdl/pfcf_pkg.sv */
// shared constants, types and helper functions of the pixel format converter
// no dependencies; used by the csr block, the pixel pipeline and the top level
package pfcf_pkg;

   localparam int MAX_WIDTH     = 4096;
   localparam int MAX_HEIGHT    = 4096;
   localparam int PALETTE_DEPTH = 256;

   localparam int DIM_W    = 13;
   localparam int PITCH_W  = 15;
   localparam int PCOUNT_W = 9;
   localparam int ADDR_W   = 26;
   localparam int PIXEL_W  = 32;
   localparam int ENTRY_W  = 24;
   localparam int PADDR_W  = 5;
   localparam int PDATA_W  = 32;

   localparam int COL_W = $clog2(MAX_WIDTH);
   localparam int ROW_W = $clog2(MAX_HEIGHT);
   localparam int PAL_AW = $clog2(PALETTE_DEPTH);
   localparam int CMP_BASE = (COL_W > ROW_W) ? COL_W : ROW_W;
   localparam int CMP_W = ((CMP_BASE > DIM_W) ? CMP_BASE : DIM_W) + 1;

   typedef logic [CMP_W-1:0]           cmp_type;
   typedef logic [ADDR_W-1:0]          addr_type;
   typedef logic [ROW_W+PITCH_W-1:0]   prod_type;

   // request commands
   localparam logic CMD_LOAD    = 1'b0;
   localparam logic CMD_CONVERT = 1'b1;

   // source pixel modes
   localparam logic [1:0] MODE_INDEXED = 2'd0;
   localparam logic [1:0] MODE_RGB16   = 2'd1;
   localparam logic [1:0] MODE_BGR24   = 2'd2;
   localparam logic [1:0] MODE_BGRA32  = 2'd3;

   // register indexes
   localparam logic [2:0] REG_MODE     = 3'd0;
   localparam logic [2:0] REG_WIDTH    = 3'd1;
   localparam logic [2:0] REG_HEIGHT   = 3'd2;
   localparam logic [2:0] REG_TOP_DOWN = 3'd3;
   localparam logic [2:0] REG_PCOUNT   = 3'd4;
   localparam logic [2:0] REG_PITCH    = 3'd5;

   typedef struct packed {
      logic [1:0]          mode;
      cmp_type             width;
      cmp_type             height;
      logic                top_down;
      logic [PCOUNT_W-1:0] pal_count;
      logic [PITCH_W-1:0]  pitch;
   } cfg_type;

   function automatic cmp_type clamp_dim(input logic [DIM_W-1:0] v, input cmp_type maxv);
      cmp_type r;
      if (v == '0) begin
         r = cmp_type'(1);
      end else if (cmp_type'(v) > maxv) begin
         r = maxv;
      end else begin
         r = cmp_type'(v);
      end
      return r;
   endfunction

   function automatic logic [2:0] bytes_for_mode(input logic [1:0] mode);
      logic [2:0] n;
      unique case (mode)
         MODE_INDEXED: n = 3'd3;
         MODE_RGB16:   n = 3'd2;
         MODE_BGR24:   n = 3'd3;
         MODE_BGRA32:  n = 3'd4;
         default:      n = 3'd3;
      endcase
      return n;
   endfunction

endpackage

/* hdl/pfcf_ram.sv */
// generic single-port-write, single-port-read ram with registered read data
// no dependencies
module pfcf_ram #(
   parameter int WIDTH = 24,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

/* hdl/pfcf_csr.sv */
// apb-style configuration registers of the pixel converter
// depends on pfcf_pkg for register indexes, widths and the config struct
module pfcf_csr (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         psel,
   input  logic                         penable,
   input  logic                         pwrite,
   input  logic [pfcf_pkg::PADDR_W-1:0] paddr,
   input  logic [pfcf_pkg::PDATA_W-1:0] pwdata,
   output logic [pfcf_pkg::PDATA_W-1:0] prdata,
   output logic                         pready,
   output pfcf_pkg::cfg_type            cfg,
   output logic                         restart
);

   logic [1:0]                    mode_ff;
   logic [pfcf_pkg::DIM_W-1:0]    width_ff;
   logic [pfcf_pkg::DIM_W-1:0]    height_ff;
   logic                          top_down_ff;
   logic [pfcf_pkg::PCOUNT_W-1:0] pcount_ff;
   logic [pfcf_pkg::PITCH_W-1:0]  pitch_ff;
   logic [2:0]                    index;
   logic                          wr_en;

   assign index  = paddr[4:2];
   assign wr_en  = psel && penable && pwrite;
   assign pready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff     <= pfcf_pkg::MODE_BGR24;
         width_ff    <= pfcf_pkg::DIM_W'(1);
         height_ff   <= pfcf_pkg::DIM_W'(1);
         top_down_ff <= 1'b0;
         pcount_ff   <= '0;
         pitch_ff    <= '0;
      end else if (wr_en) begin
         unique case (index)
            pfcf_pkg::REG_MODE:     mode_ff     <= pwdata[1:0];
            pfcf_pkg::REG_WIDTH:    width_ff    <= pwdata[pfcf_pkg::DIM_W-1:0];
            pfcf_pkg::REG_HEIGHT:   height_ff   <= pwdata[pfcf_pkg::DIM_W-1:0];
            pfcf_pkg::REG_TOP_DOWN: top_down_ff <= pwdata[0];
            pfcf_pkg::REG_PCOUNT:   pcount_ff   <= pwdata[pfcf_pkg::PCOUNT_W-1:0];
            pfcf_pkg::REG_PITCH:    pitch_ff    <= pwdata[pfcf_pkg::PITCH_W-1:0];
            default: ;
         endcase
      end
   end

   // a geometry write starts a new frame
   assign restart = wr_en && (index == pfcf_pkg::REG_WIDTH || index == pfcf_pkg::REG_HEIGHT);

   always_comb begin
      unique case (index)
         pfcf_pkg::REG_MODE:     prdata = pfcf_pkg::PDATA_W'(mode_ff);
         pfcf_pkg::REG_WIDTH:    prdata = pfcf_pkg::PDATA_W'(width_ff);
         pfcf_pkg::REG_HEIGHT:   prdata = pfcf_pkg::PDATA_W'(height_ff);
         pfcf_pkg::REG_TOP_DOWN: prdata = pfcf_pkg::PDATA_W'(top_down_ff);
         pfcf_pkg::REG_PCOUNT:   prdata = pfcf_pkg::PDATA_W'(pcount_ff);
         pfcf_pkg::REG_PITCH:    prdata = pfcf_pkg::PDATA_W'(pitch_ff);
         default:                prdata = '0;
      endcase
   end

   always_comb begin
      cfg.mode      = mode_ff;
      cfg.width     = pfcf_pkg::clamp_dim(width_ff, pfcf_pkg::cmp_type'(pfcf_pkg::MAX_WIDTH));
      cfg.height    = pfcf_pkg::clamp_dim(height_ff, pfcf_pkg::cmp_type'(pfcf_pkg::MAX_HEIGHT));
      cfg.top_down  = top_down_ff;
      cfg.pal_count = pcount_ff;
      cfg.pitch     = pitch_ff;
   end

endmodule

/* hdl/pfcf_pipe.sv */
// pixel pipeline: position counters, palette ram access, format and address stage
// depends on pfcf_pkg, pfcf_ram and assert_macros.svh
`include "assert_macros.svh"

module pfcf_pipe (
   input  logic                         clock,
   input  logic                         reset,
   input  pfcf_pkg::cfg_type            cfg,
   input  logic                         restart,
   input  logic                         req_valid,
   output logic                         req_ready,
   input  logic                         req_command,
   input  logic [pfcf_pkg::PIXEL_W-1:0] req_source_pixel,
   input  logic [7:0]                   req_entry_index,
   input  logic [7:0]                   req_entry_red,
   input  logic [7:0]                   req_entry_green,
   input  logic [7:0]                   req_entry_blue,
   output logic                         rsp_valid,
   input  logic                         rsp_ready,
   output logic [pfcf_pkg::ADDR_W-1:0]  rsp_dest_address,
   output logic [pfcf_pkg::PIXEL_W-1:0] rsp_pixel_value,
   output logic [2:0]                   rsp_byte_count,
   output logic                         rsp_frame_end
);

   logic [pfcf_pkg::COL_W-1:0] col_ff, col_in;
   logic [pfcf_pkg::ROW_W-1:0] row_ff, row_in;
   logic                       advance, accept, conv, load;
   logic                       col_last, row_last;
   logic [pfcf_pkg::ROW_W-1:0] dest_row;
   logic [7:0]                 pix_index;
   logic                       pal_hit;
   logic                       ram_wr_en;
   logic [pfcf_pkg::ENTRY_W-1:0] ram_q;

   logic                         s1_valid_ff;
   logic [1:0]                   s1_mode_ff;
   logic [pfcf_pkg::PIXEL_W-1:0] s1_src_ff;
   logic                         s1_hit_ff;
   logic [pfcf_pkg::ROW_W-1:0]   s1_row_ff;
   logic [pfcf_pkg::COL_W-1:0]   s1_col_ff;
   logic                         s1_end_ff;

   logic                         out_valid_ff;
   logic [pfcf_pkg::ADDR_W-1:0]  out_addr_ff;
   logic [pfcf_pkg::PIXEL_W-1:0] out_value_ff;
   logic [2:0]                   out_bytes_ff;
   logic                         out_end_ff;

   logic [2:0]                   nbytes;
   logic [pfcf_pkg::PIXEL_W-1:0] value;
   pfcf_pkg::prod_type           row_off;
   pfcf_pkg::addr_type           col_off;
   pfcf_pkg::addr_type           addr;

   // stage 1 moves whenever it is empty or the output register frees up
   assign advance   = !out_valid_ff || rsp_ready;
   assign req_ready = !s1_valid_ff || advance;
   assign accept    = req_valid && req_ready;
   assign conv      = accept && (req_command == pfcf_pkg::CMD_CONVERT);
   assign load      = accept && (req_command == pfcf_pkg::CMD_LOAD);

   // counters stay below the clamped geometry since geometry writes clear them
   assign col_last = pfcf_pkg::cmp_type'(col_ff) == (cfg.width - pfcf_pkg::cmp_type'(1));
   assign row_last = pfcf_pkg::cmp_type'(row_ff) == (cfg.height - pfcf_pkg::cmp_type'(1));
   assign dest_row = cfg.top_down ? row_ff
                   : pfcf_pkg::ROW_W'(cfg.height - pfcf_pkg::cmp_type'(1)
                                      - pfcf_pkg::cmp_type'(row_ff));

   assign pix_index = req_source_pixel[7:0];
   assign pal_hit   = ({1'b0, pix_index} < cfg.pal_count)
                   && (32'(pix_index) < 32'(pfcf_pkg::PALETTE_DEPTH));
   assign ram_wr_en = load && (32'(req_entry_index) < 32'(pfcf_pkg::PALETTE_DEPTH));

   // read only on a convert so the read data holds while stage 1 is stalled
   pfcf_ram #(
      .WIDTH(pfcf_pkg::ENTRY_W),
      .DEPTH(pfcf_pkg::PALETTE_DEPTH)
   ) u_palette (
      .clock  (clock),
      .wr_en  (ram_wr_en),
      .wr_addr(req_entry_index[pfcf_pkg::PAL_AW-1:0]),
      .wr_data({req_entry_blue, req_entry_green, req_entry_red}),
      .rd_en  (conv),
      .rd_addr(pix_index[pfcf_pkg::PAL_AW-1:0]),
      .rd_data(ram_q)
   );

   always_comb begin
      col_in = col_ff;
      row_in = row_ff;
      if (restart) begin
         col_in = '0;
         row_in = '0;
      end else if (conv) begin
         if (col_last) begin
            col_in = '0;
            row_in = row_last ? '0 : row_ff + pfcf_pkg::ROW_W'(1);
         end else begin
            col_in = col_ff + pfcf_pkg::COL_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff       <= '0;
         row_ff       <= '0;
         s1_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         col_ff <= col_in;
         row_ff <= row_in;
         if (req_ready) begin
            s1_valid_ff <= conv;
         end
         if (advance) begin
            out_valid_ff <= s1_valid_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (conv) begin
         s1_mode_ff <= cfg.mode;
         s1_src_ff  <= req_source_pixel;
         s1_hit_ff  <= pal_hit;
         s1_row_ff  <= dest_row;
         s1_col_ff  <= col_ff;
         s1_end_ff  <= col_last && row_last;
      end
   end

   assign nbytes = pfcf_pkg::bytes_for_mode(s1_mode_ff);

   always_comb begin
      unique case (s1_mode_ff)
         pfcf_pkg::MODE_INDEXED: value = s1_hit_ff ? pfcf_pkg::PIXEL_W'(ram_q) : '0;
         pfcf_pkg::MODE_RGB16:   value = {16'd0, s1_src_ff[15:0]};
         pfcf_pkg::MODE_BGR24:   value = {8'd0, s1_src_ff[7:0], s1_src_ff[15:8],
                                          s1_src_ff[23:16]};
         pfcf_pkg::MODE_BGRA32:  value = {s1_src_ff[31:24], s1_src_ff[7:0],
                                          s1_src_ff[15:8], s1_src_ff[23:16]};
         default:                value = '0;
      endcase
   end

   assign row_off = pfcf_pkg::prod_type'(s1_row_ff) * pfcf_pkg::prod_type'(cfg.pitch);
   assign col_off = pfcf_pkg::addr_type'(s1_col_ff) * pfcf_pkg::addr_type'(nbytes);
   assign addr    = pfcf_pkg::addr_type'(row_off) + col_off;

   always_ff @(posedge clock) begin
      if (advance) begin
         out_addr_ff  <= addr;
         out_value_ff <= value;
         out_bytes_ff <= nbytes;
         out_end_ff   <= s1_end_ff;
      end
   end

   assign rsp_valid        = out_valid_ff;
   assign rsp_dest_address = out_addr_ff;
   assign rsp_pixel_value  = out_value_ff;
   assign rsp_byte_count   = out_bytes_ff;
   assign rsp_frame_end    = out_end_ff;

   `ASSERT_PROP(a_ready_when_empty, clock, reset, !s1_valid_ff |-> req_ready)
   `ASSERT_PROP(a_col_in_range, clock, reset, pfcf_pkg::cmp_type'(col_ff) < cfg.width)
   `ASSERT_PROP(a_row_in_range, clock, reset, pfcf_pkg::cmp_type'(row_ff) < cfg.height)
   `ASSERT_NEXT(a_frame_wrap, clock, reset, conv && col_last && row_last, col_ff == '0 && row_ff == '0)
   `ASSERT_NEXT(a_load_no_result, clock, reset, load, !s1_valid_ff)

endmodule

/* hdl/pixel_format_converter_flip.sv */
// pipeline: a convert request is registered in stage 1 and then in the output register
// throughput: one request per clock while rsp_ready does not stall the output;
// loads give no result
// reset: synchronous, registers return to defaults and counters to zero;
// palette contents are undefined until loaded, no clearing pass is run
module pixel_format_converter_flip (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         psel,
   input  logic                         penable,
   input  logic                         pwrite,
   input  logic [pfcf_pkg::PADDR_W-1:0] paddr,
   input  logic [pfcf_pkg::PDATA_W-1:0] pwdata,
   output logic [pfcf_pkg::PDATA_W-1:0] prdata,
   output logic                         pready,
   input  logic                         req_valid,
   output logic                         req_ready,
   input  logic                         req_command,
   input  logic [pfcf_pkg::PIXEL_W-1:0] req_source_pixel,
   input  logic [7:0]                   req_entry_index,
   input  logic [7:0]                   req_entry_red,
   input  logic [7:0]                   req_entry_green,
   input  logic [7:0]                   req_entry_blue,
   output logic                         rsp_valid,
   input  logic                         rsp_ready,
   output logic [pfcf_pkg::ADDR_W-1:0]  rsp_dest_address,
   output logic [pfcf_pkg::PIXEL_W-1:0] rsp_pixel_value,
   output logic [2:0]                   rsp_byte_count,
   output logic                         rsp_frame_end
);

   pfcf_pkg::cfg_type cfg;
   logic              restart;

   pfcf_csr u_csr (
      .clock  (clock),
      .reset  (reset),
      .psel   (psel),
      .penable(penable),
      .pwrite (pwrite),
      .paddr  (paddr),
      .pwdata (pwdata),
      .prdata (prdata),
      .pready (pready),
      .cfg    (cfg),
      .restart(restart)
   );

   pfcf_pipe u_pipe (
      .clock           (clock),
      .reset           (reset),
      .cfg             (cfg),
      .restart         (restart),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_command     (req_command),
      .req_source_pixel(req_source_pixel),
      .req_entry_index (req_entry_index),
      .req_entry_red   (req_entry_red),
      .req_entry_green (req_entry_green),
      .req_entry_blue  (req_entry_blue),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_dest_address(rsp_dest_address),
      .rsp_pixel_value (rsp_pixel_value),
      .rsp_byte_count  (rsp_byte_count),
      .rsp_frame_end   (rsp_frame_end)
   );

endmodule
